@@ sv/dstq_pkg.sv @@
// Package for the deadline-sorted timer queue: payload structs, result codes,
// controller states and the command/status structs. Depends on nothing.
`default_nettype none
package dstq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TIME_BITS   = 48;
  localparam int US_PER_MS       = 1000;
  localparam int CFG_IDX_W       = 8;

  localparam logic [15:0] MAX_DELAY_RST   = 16'(30 * 1000);
  localparam logic [6:0]  MAX_PENDING_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENDING = 8'd1;

  localparam logic [2:0] STS_ACCEPTED  = 3'd0;
  localparam logic [2:0] STS_BAD_DELAY = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_EXPIRED   = 3'd3;
  localparam logic [2:0] STS_NONE_DUE  = 3'd4;

  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [47:0] now_us;
    logic [15:0] delay_ms;
    logic [15:0] task_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] expired_tag;
    logic [47:0] deadline_us;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_SCHED,
    S_POP
  } state_t;

  typedef struct packed {
    logic load_item;
    logic calc_mul;
    logic calc_add;
    logic do_sched;
    logic do_pop;
  } cmd_t;

  typedef struct packed {
    logic in_kind;
    logic out_free;
    logic more_due;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/deadline_sorted_timer_queue_unit.sv @@
// Top level of the deadline-sorted timer queue.
// Depends on dstq_pkg, dstq_ctrl and dstq_dp.
`default_nettype none
// Holds up to QUEUE_DEPTH timer entries (deadline in us, 16-bit tag) sorted by
// ascending deadline in a row of shift-insert cells. A schedule item passes
// through accept, delay*1000 multiply, saturating add and insert, in that
// order. A tick is accepted and then gives one expired entry per cycle (one
// pop out of the head cell while the result register is free), or a single
// none-due result when nothing is due; result back-pressure holds both the
// insert and each pop. The rate is set by the single controller sequence and
// the single head-pop port. Results sit in an output register, so a new item
// is accepted while the last result still waits. Config writes are always
// ready and take effect on the next cycle.
module deadline_sorted_timer_queue_unit #(
  parameter int QUEUE_DEPTH = dstq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = dstq_pkg::DEF_TIME_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  dstq_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output dstq_pkg::out_item_t           out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [dstq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [15:0]                    cfg_data
);
  import dstq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dstq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dstq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

@@ sv/dstq_ctrl.sv @@
// Controller FSM for the timer queue: sequences schedule and tick items.
// Depends on dstq_pkg.
`default_nettype none
module dstq_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  dstq_pkg::sts_t sts,
  output dstq_pkg::cmd_t cmd
);
  import dstq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (sts.in_kind == KIND_TICK) ? S_POP : S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_SCHED;
      S_SCHED: if (sts.out_free) state_nxt = S_IDLE;
      S_POP:   if (sts.out_free && !sts.more_due) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_MUL:   cmd.calc_mul = 1'b1;
      S_ADD:   cmd.calc_add = 1'b1;
      S_SCHED: cmd.do_sched = sts.out_free;
      S_POP:   cmd.do_pop   = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/dstq_dp.sv @@
// Datapath for the timer queue: config registers, deadline arithmetic,
// shift-insert entry cells, pending count and output register. Uses dstq_pkg.
`default_nettype none
module dstq_dp #(
  parameter int QUEUE_DEPTH = dstq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = dstq_pkg::DEF_TIME_BITS
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  dstq_pkg::in_item_t                in_data,
  input  wire                               cfg_valid,
  input  wire [dstq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [15:0]                        cfg_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output dstq_pkg::out_item_t               out_data,
  input  dstq_pkg::cmd_t                    cmd,
  output dstq_pkg::sts_t                    sts
);
  import dstq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  in_item_t             item_r;
  logic [25:0]          prod_r;
  logic                 bad_r, full_r;
  logic [TIME_BITS-1:0] dl_r;
  logic [TIME_BITS-1:0] dl_q [QUEUE_DEPTH];
  logic [15:0]          tag_q [QUEUE_DEPTH];
  logic [CNT_W-1:0]     count_r;
  logic [15:0]          max_delay_r;
  logic [6:0]           max_pend_r;
  out_item_t            out_r;
  logic                 out_valid_r;

  logic [63:0]          now64;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS:0]   sum;
  logic [QUEUE_DEPTH-1:0] lt;
  logic                 head_due, more_due, ins_ok;
  logic [63:0]          dl_ext, head_ext;

  assign now64    = {16'b0, item_r.now_us};
  assign now_w    = now64[TIME_BITS-1:0];
  assign sum      = {1'b0, now_w} + (TIME_BITS+1)'(prod_r);
  assign dl_ext   = 64'(dl_r);
  assign head_ext = 64'(dl_q[0]);
  assign head_due = (count_r != '0) && (dl_q[0] <= now_w);
  assign more_due = head_due && (count_r >= CNT_W'(2)) && (dl_q[1] <= now_w);
  assign ins_ok   = !bad_r && !full_r;

  // prefix of cells that stay ahead of the new entry
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++)
      lt[i] = (CNT_W'(i) < count_r) && (dl_q[i] < dl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r <= MAX_DELAY_RST;
      max_pend_r  <= MAX_PENDING_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MAX_DELAY)   max_delay_r <= cfg_data;
      if (cfg_index == CFG_MAX_PENDING) max_pend_r  <= cfg_data[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.calc_mul) begin
      prod_r <= 26'(item_r.delay_ms) * 26'(US_PER_MS);
      bad_r  <= (item_r.delay_ms == 16'd0) || (item_r.delay_ms >= max_delay_r);
      full_r <= (7'(count_r) >= max_pend_r) || (count_r == CNT_W'(QUEUE_DEPTH));
    end
    if (cmd.calc_add) dl_r <= sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  end

  // entry cells: insert shifts the tail right, pop shifts everything left
  always_ff @(posedge clk) begin
    if (cmd.do_sched && ins_ok) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!lt[i]) begin
          if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
            dl_q[i]  <= dl_r;
            tag_q[i] <= item_r.task_tag;
          end else begin
            dl_q[i]  <= dl_q[(i == 0) ? 0 : i-1];
            tag_q[i] <= tag_q[(i == 0) ? 0 : i-1];
          end
        end
      end
    end else if (cmd.do_pop && head_due) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        dl_q[i]  <= dl_q[i+1];
        tag_q[i] <= tag_q[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.do_sched && ins_ok) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.do_pop && head_due) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_sched) begin
      if (bad_r)       out_r <= '{STS_BAD_DELAY, 16'd0, 48'd0, 1'b1};
      else if (full_r) out_r <= '{STS_FULL, 16'd0, 48'd0, 1'b1};
      else             out_r <= '{STS_ACCEPTED, item_r.task_tag, dl_ext[47:0], 1'b1};
    end else if (cmd.do_pop) begin
      if (head_due) out_r <= '{STS_EXPIRED, tag_q[0], head_ext[47:0], !more_due};
      else          out_r <= '{STS_NONE_DUE, 16'd0, 48'd0, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                         out_valid_r <= 1'b0;
    else if (cmd.do_sched || cmd.do_pop) out_valid_r <= 1'b1;
    else if (out_ready)                 out_valid_r <= 1'b0;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.in_kind  = in_data.kind;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.more_due = more_due;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH)) else $error("pending count above depth");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_pop && head_due) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not decrement count");
  a_ins_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_sched && ins_ok) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not increment count");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.do_sched || cmd.do_pop))
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire
